>>> hw/rtl/nrb_pkg.sv
// Shared types, widths and defaults for the n-th root bisection core.
package nrb_pkg;

	// Defaults for the top-level parameters
	localparam int FRAC_BITS_DEF  = 16;
	localparam int MAX_DEGREE_DEF = 32;
	localparam int IN_WIDTH_DEF   = 32;

	// Fixed field widths
	localparam int RADICAND_W = 32;
	localparam int DEGREE_W   = 6;
	localparam int ROOT_W     = 48;
	localparam int RAD_EXT_W  = 40;    // radicand zero-extended to the widest IN_WIDTH
	localparam int S_DATA_W   = 40;    // radicand + degree, padded to bytes
	localparam int M_DATA_W   = 56;    // root + exact, padded to bytes

	// Multiplier limb width
	localparam int LIMB_W = 32;

	// Controller to datapath commands
	typedef struct packed {
		logic load;         // take a new item from the input transfer
		logic step_init;    // latch midpoint, reset power and degree count
		logic mul_start;    // launch power * midpoint
		logic take_p;       // keep truncated product as new power
		logic set_hi;       // upper bound := midpoint
		logic set_lo;       // lower bound := midpoint
		logic set_exact;    // exact match found
		logic out_load;     // load the output register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic cont;         // interval wider than one LSB
		logic mul_done;     // product ready
		logic gt;           // truncated product above target
		logic last;         // this is the final multiplication
		logic eq;           // power equals target
	} sts_t;

endpackage

>>> hw/rtl/nrb_mul.sv
// Sequential multiplier: one 32x32 partial product per cycle, accumulated.
module nrb_mul #(
	parameter int W = 48
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic           done,
	output logic [2*W-1:0] prod
);
	import nrb_pkg::*;

	localparam int L   = (W + LIMB_W - 1) / LIMB_W;
	localparam int LW  = L * LIMB_W;
	localparam int AW  = 2 * LW;
	localparam int IW  = (L > 1) ? $clog2(L) : 1;
	localparam int PSW = (2 * L > 2) ? $clog2(2 * L) : 1;

	logic [LW-1:0]       a_q, b_q;
	logic [IW-1:0]       i_q, j_q;
	logic                busy_q;
	logic                i_end, j_end;
	logic [2*LIMB_W-1:0] pp_s1;
	logic [PSW-1:0]      pos_s1;
	logic                vld_s1, last_s1;
	logic [AW-1:0]       acc_q;
	logic                done_q;

	assign i_end = (i_q == IW'(L - 1));
	assign j_end = (j_q == IW'(L - 1));

	// Limb sequencing and partial-product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			done_q <= vld_s1 && last_s1;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
				j_q    <= '0;
				vld_s1 <= 1'b0;
			end else if (busy_q) begin
				vld_s1  <= 1'b1;
				last_s1 <= i_end && j_end;
				if (j_end) begin
					j_q <= '0;
					i_q <= i_q + IW'(1);
					if (i_end) begin
						busy_q <= 1'b0;
					end
				end else begin
					j_q <= j_q + IW'(1);
				end
			end else begin
				vld_s1 <= 1'b0;
			end
		end
	end

	// Operands, partial product and accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= LW'(a);
			b_q   <= LW'(b);
			acc_q <= '0;
		end else begin
			if (busy_q) begin
				pp_s1  <= a_q[i_q*LIMB_W +: LIMB_W] * b_q[j_q*LIMB_W +: LIMB_W];
				pos_s1 <= PSW'(i_q) + PSW'(j_q);
			end
			if (vld_s1) begin
				acc_q <= acc_q + (AW'(pp_s1) << (pos_s1 * LIMB_W));
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q[2*W-1:0];

endmodule

>>> hw/rtl/nrb_dpath.sv
// Datapath: bounds, midpoint, running power, compares and output register.
module nrb_dpath #(
	parameter int FRAC_BITS  = 16,
	parameter int MAX_DEGREE = 32,
	parameter int IN_WIDTH   = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  nrb_pkg::cmd_t                 cmd,
	output nrb_pkg::sts_t                 sts,
	input  logic [nrb_pkg::S_DATA_W-1:0]  s_tdata,
	output logic [nrb_pkg::M_DATA_W-1:0]  m_tdata
);
	import nrb_pkg::*;

	localparam int W  = IN_WIDTH + FRAC_BITS;
	localparam int PW = 2 * W - FRAC_BITS;
	localparam int DW = $clog2(MAX_DEGREE + 1);
	localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

	logic [RADICAND_W-1:0] radicand;
	logic [DEGREE_W-1:0]   degree;
	logic [RAD_EXT_W-1:0]  rad_ext;
	logic [DEGREE_W:0]     deg_clamp;
	logic [W-1:0]          tgt_q, lo_q, hi_q, x_q, p_q, mid;
	logic [DW-1:0]         cnt_q;
	logic [DW-1:0]         n_q;
	logic                  exact_q;
	logic                  mul_done;
	logic [2*W-1:0]        prod;
	logic [PW-1:0]         p_new;
	logic [W-1:0]          res;
	logic [M_DATA_W-1:0]   out_q;

	assign radicand = s_tdata[RADICAND_W-1:0];
	assign degree   = s_tdata[RADICAND_W +: DEGREE_W];
	assign rad_ext  = RAD_EXT_W'(radicand);

	// Degree zero acts as one; large degrees saturate
	always_comb begin
		if (degree == '0) begin
			deg_clamp = (DEGREE_W+1)'(1);
		end else if ((DEGREE_W+1)'(degree) > (DEGREE_W+1)'(MAX_DEGREE)) begin
			deg_clamp = (DEGREE_W+1)'(MAX_DEGREE);
		end else begin
			deg_clamp = (DEGREE_W+1)'(degree);
		end
	end

	assign mid   = lo_q + ((hi_q - lo_q) >> 1);
	assign p_new = prod[2*W-1:FRAC_BITS];
	assign res   = exact_q ? x_q : lo_q;

	assign sts.cont     = (W+1)'(hi_q) > ((W+1)'(lo_q) + (W+1)'(1));
	assign sts.mul_done = mul_done;
	assign sts.gt       = p_new > PW'(tgt_q);
	assign sts.last     = (cnt_q == DW'(1));
	assign sts.eq       = (p_q == tgt_q);

	nrb_mul #(
		.W (W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (p_q),
		.b      (x_q),
		.done   (mul_done),
		.prod   (prod)
	);

	// Search registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tgt_q   <= {rad_ext[IN_WIDTH-1:0], {FRAC_BITS{1'b0}}};
			hi_q    <= {rad_ext[IN_WIDTH-1:0], {FRAC_BITS{1'b0}}};
			lo_q    <= ONE;
			n_q     <= DW'(deg_clamp);
			exact_q <= 1'b0;
		end
		if (cmd.step_init) begin
			x_q   <= mid;
			p_q   <= ONE;
			cnt_q <= n_q;
		end
		if (cmd.take_p) begin
			p_q   <= p_new[W-1:0];
			cnt_q <= cnt_q - DW'(1);
		end
		if (cmd.set_hi) begin
			hi_q <= x_q;
		end
		if (cmd.set_lo) begin
			lo_q <= x_q;
		end
		if (cmd.set_exact) begin
			exact_q <= 1'b1;
		end
		if (cmd.out_load) begin
			out_q <= M_DATA_W'({exact_q, ROOT_W'(res)});
		end
	end

	assign m_tdata = out_q;

endmodule

>>> hw/rtl/nrb_ctrl.sv
// Controller FSM: sequences bisection steps, multiplications and output.
module nrb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  nrb_pkg::sts_t sts,
	output nrb_pkg::cmd_t cmd
);
	import nrb_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_WAIT  = 3'd3;
	localparam logic [2:0] ST_EVAL  = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0] state_q, state_d;
	logic       out_vld_q;
	logic       out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_vld_q;
	assign out_free = !out_vld_q || m_tready;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.cont) begin
					cmd.step_init = 1'b1;
					state_d       = ST_MUL;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_MUL: begin
				cmd.mul_start = 1'b1;
				state_d       = ST_WAIT;
			end
			ST_WAIT: begin
				if (sts.mul_done) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sts.gt) begin
					cmd.set_hi = 1'b1;
					state_d    = ST_CHECK;
				end else begin
					cmd.take_p = 1'b1;
					state_d    = sts.last ? ST_FIN : ST_MUL;
				end
			end
			ST_FIN: begin
				if (sts.eq) begin
					cmd.set_exact = 1'b1;
					state_d       = ST_DONE;
				end else begin
					cmd.set_lo = 1'b1;
					state_d    = ST_CHECK;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and output-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

>>> hw/rtl/nth_root_bisection_core.sv
// N-th root by bisection: one multiplier shared by all steps, result in a register.
// Each multiplication accumulates L*L limb partial products, L = ceil((IN_WIDTH+FRAC_BITS)/32).
// A step does up to degree multiplications, ending on the first power above the radicand;
// an equality check follows when all degree multiplications stay in range. Up to about
// IN_WIDTH+FRAC_BITS steps per item, plus any wait for the output.
// One item at a time; a new item is taken while the previous result waits at the output.
// Asynchronous active-low reset returns the controller to idle with the output empty.
module nth_root_bisection_core #(
	parameter int FRAC_BITS  = nrb_pkg::FRAC_BITS_DEF,
	parameter int MAX_DEGREE = nrb_pkg::MAX_DEGREE_DEF,
	parameter int IN_WIDTH   = nrb_pkg::IN_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [nrb_pkg::S_DATA_W-1:0] s_tdata,   // radicand[31:0], degree[37:32]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [nrb_pkg::M_DATA_W-1:0] m_tdata    // root[47:0], exact[48]
);
	import nrb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	nrb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	nrb_dpath #(
		.FRAC_BITS  (FRAC_BITS),
		.MAX_DEGREE (MAX_DEGREE),
		.IN_WIDTH   (IN_WIDTH)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata)
	);

endmodule
